// ===== sv/wrcs_pkg.sv =====
// Shared types, codes and constants of the weighted rank candidate selector.
`default_nettype none

package wrcs_pkg;

    localparam int FIELD_OBJECTIVES = 4;
    localparam int FIELD_W          = 32;
    localparam int RAW_EXT_W        = 48;
    localparam int WEIGHT_W         = 16;
    localparam int FRAC_BITS        = 16;
    localparam int NORM_W           = FRAC_BITS + 1;
    localparam int PROD_W           = NORM_W + WEIGHT_W;
    localparam int INDEX_OUT_W      = 6;
    localparam int SCORE_OUT_W      = 34;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int OBJ_COUNT_W      = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_0  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_1  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_2  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_3  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OBJ_COUNT = 3'd4;

    localparam logic [WEIGHT_W-1:0]    WEIGHT_RESET    = 16'd256;
    localparam logic [OBJ_COUNT_W-1:0] OBJ_COUNT_RESET = 3'd4;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_NO_WEIGHT = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic signed [FIELD_W-1:0] fitness_a;
        logic signed [FIELD_W-1:0] fitness_b;
        logic signed [FIELD_W-1:0] fitness_c;
        logic signed [FIELD_W-1:0] fitness_d;
        logic                      last_candidate;
    } row_t;

    typedef struct packed {
        logic [INDEX_OUT_W-1:0] best_index;
        logic [SCORE_OUT_W-1:0] best_score;
        logic [1:0]             error_code;
    } result_t;

    typedef struct packed {
        logic load_wr;
        logic rank_clr;
        logic cmp_valid;
        logic cmp_self;
        logic cmp_last;
        logic div_load;
        logic div_step;
        logic mul_en;
    } lane_ctrl_t;

    typedef struct packed {
        logic sum_en;
        logic cmp_en;
        logic first;
    } merge_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/wrcs_lane.sv =====
// One objective lane: key store, rank counting, rank divider and weighting.
`default_nettype none

module wrcs_lane
    import wrcs_pkg::*;
#(
    parameter int MAX_CANDIDATES = 64,
    parameter int FITNESS_WIDTH  = 32
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lane_ctrl_t                          ctrl,
    input  wire logic [$clog2(MAX_CANDIDATES)-1:0]   wr_addr,
    input  wire logic [FITNESS_WIDTH-1:0]            wr_key,
    input  wire logic [$clog2(MAX_CANDIDATES)-1:0]   addr_i,
    input  wire logic [$clog2(MAX_CANDIDATES)-1:0]   addr_j,
    input  wire logic [$clog2(MAX_CANDIDATES)-1:0]   rank_wr_addr,
    input  wire logic [WEIGHT_W-1:0]                 weight,
    input  wire logic                                active,
    output logic      [PROD_W-1:0]                   prod
);

    localparam int IDX_W = $clog2(MAX_CANDIDATES);
    localparam int DIV_W = IDX_W + FRAC_BITS;

    logic [FITNESS_WIDTH-1:0] key_mem [MAX_CANDIDATES];
    logic [IDX_W-1:0]         rank_mem [MAX_CANDIDATES];

    logic [FITNESS_WIDTH-1:0] key_i_reg;
    logic [FITNESS_WIDTH-1:0] key_j_reg;
    logic [IDX_W-1:0]         rank_rd_reg;

    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  cnt_final;
    logic [IDX_W-1:0]  max_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [NORM_W-1:0] quo_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [IDX_W:0]    trial;
    logic              ge;
    logic              inc;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_wr)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        key_i_reg <= key_mem[addr_i];
        key_j_reg <= key_mem[addr_j];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_valid && ctrl.cmp_last)
        begin
            rank_mem[rank_wr_addr] <= cnt_final;
        end
        rank_rd_reg <= rank_mem[addr_i];
    end

    assign inc       = !ctrl.cmp_self && (key_i_reg > key_j_reg);
    assign cnt_final = cnt_reg + IDX_W'(inc);

    // Restoring division of rank * 2^16 by the largest rank, one bit a cycle.
    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, max_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            max_reg <= '0;
        end
        else if (ctrl.rank_clr)
        begin
            cnt_reg <= '0;
            max_reg <= '0;
        end
        else if (ctrl.cmp_valid)
        begin
            if (ctrl.cmp_last)
            begin
                cnt_reg <= '0;
                if (cnt_final > max_reg)
                begin
                    max_reg <= cnt_final;
                end
            end
            else
            begin
                cnt_reg <= cnt_final;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.div_load)
        begin
            rem_reg <= '0;
            dvd_reg <= {rank_rd_reg, {FRAC_BITS{1'b0}}};
            quo_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= ge ? IDX_W'(trial - {1'b0, max_reg}) : IDX_W'(trial);
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[NORM_W-2:0], ge};
        end
        if (ctrl.mul_en)
        begin
            if (active && (max_reg != '0))
            begin
                prod_reg <= {{WEIGHT_W{1'b0}}, quo_reg} * {{NORM_W{1'b0}}, weight};
            end
            else
            begin
                prod_reg <= '0;
            end
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== sv/wrcs_merge.sv =====
// Merging stage: sums the lane products and keeps the lowest score.
`default_nettype none

module wrcs_merge
    import wrcs_pkg::*;
#(
    parameter int MAX_CANDIDATES = 64,
    parameter int NUM_OBJECTIVES = 4
)
(
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire merge_ctrl_t                                ctrl,
    input  wire logic [$clog2(MAX_CANDIDATES)-1:0]          idx,
    input  wire logic [NUM_OBJECTIVES-1:0][PROD_W-1:0]      prod,
    output logic      [PROD_W+$clog2(NUM_OBJECTIVES)-1:0]   best_score,
    output logic      [$clog2(MAX_CANDIDATES)-1:0]          best_index
);

    localparam int IDX_W   = $clog2(MAX_CANDIDATES);
    localparam int SCORE_W = PROD_W + $clog2(NUM_OBJECTIVES);

    logic [SCORE_W-1:0] sum_comb;
    logic [SCORE_W-1:0] sum_reg;
    logic [SCORE_W-1:0] best_reg;
    logic [IDX_W-1:0]   best_idx_reg;

    always_comb
    begin
        sum_comb = '0;
        for (int l = 0; l < NUM_OBJECTIVES; l++)
        begin
            sum_comb = sum_comb + SCORE_W'(prod[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            sum_reg <= sum_comb;
        end
    end

    // Strictly lower wins, so the first candidate is kept on ties.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg     <= '0;
            best_idx_reg <= '0;
        end
        else if (ctrl.cmp_en && (ctrl.first || (sum_reg < best_reg)))
        begin
            best_reg     <= sum_reg;
            best_idx_reg <= idx;
        end
    end

    assign best_score = best_reg;
    assign best_index = best_idx_reg;

endmodule

`default_nettype wire

// ===== sv/weighted_rank_candidate_select.sv =====
// Weighted rank candidate selector: rows load one per cycle while busy is low; a row with
// last_candidate set starts ranking. Every objective has its own lane, so all objectives
// are ranked at once. Ranking makes one compare per cycle through the key store's two read
// ports; then each candidate is normalized by the bit-serial rank divider, weighted, summed
// and compared, and the result comes on result with result_valid high for one cycle; it
// must be taken then. Overflow and all-zero-weight results come in the cycle after the last
// row. Busy stays high while ranking.
`default_nettype none

module weighted_rank_candidate_select
    import wrcs_pkg::*;
#(
    parameter int MAX_CANDIDATES = 64,
    parameter int NUM_OBJECTIVES = 4,
    parameter int FITNESS_WIDTH  = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire row_t                    row,
    output logic                         result_valid,
    output result_t                      result,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W   = $clog2(MAX_CANDIDATES);
    localparam int CNT_W   = $clog2(MAX_CANDIDATES + 1);
    localparam int DIV_W   = IDX_W + FRAC_BITS;
    localparam int DCNT_W  = $clog2(DIV_W);
    localparam int SCORE_W = PROD_W + $clog2(NUM_OBJECTIVES);
    localparam int SX_W    = (SCORE_W > SCORE_OUT_W) ? SCORE_W : SCORE_OUT_W;
    localparam int IX_W    = (IDX_W > INDEX_OUT_W) ? IDX_W : INDEX_OUT_W;
    localparam int KMAX    = (NUM_OBJECTIVES < FIELD_OBJECTIVES) ? NUM_OBJECTIVES
                                                                 : FIELD_OBJECTIVES;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RANK   = 4'd1;
    localparam logic [3:0] S_RDRAIN = 4'd2;
    localparam logic [3:0] S_NREAD  = 4'd3;
    localparam logic [3:0] S_NLOAD  = 4'd4;
    localparam logic [3:0] S_NDIV   = 4'd5;
    localparam logic [3:0] S_NMUL   = 4'd6;
    localparam logic [3:0] S_NSUM   = 4'd7;
    localparam logic [3:0] S_NCMP   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  row_count_reg, row_count_next;
    logic              overflow_reg, overflow_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic              cmp_self_reg, cmp_self_next;
    logic              cmp_last_reg, cmp_last_next;
    logic [IDX_W-1:0]  cmp_i_reg, cmp_i_next;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    logic [WEIGHT_W-1:0]    weight_reg [FIELD_OBJECTIVES];
    logic [OBJ_COUNT_W-1:0] obj_count_reg;

    logic [3:0]        k_act;
    logic              any_weight;
    logic              accept;
    logic              room;
    logic              i_last;
    logic              j_last;
    lane_ctrl_t        lane_ctrl;
    merge_ctrl_t       merge_ctrl;
    logic [FIELD_W-1:0] field [FIELD_OBJECTIVES];
    logic [NUM_OBJECTIVES-1:0][PROD_W-1:0] prod;
    logic [SCORE_W-1:0] best_score;
    logic [IDX_W-1:0]   best_index;
    logic [SX_W-1:0]    score_ext;
    logic [IX_W-1:0]    index_ext;

    assign field[0] = row.fitness_a;
    assign field[1] = row.fitness_b;
    assign field[2] = row.fitness_c;
    assign field[3] = row.fitness_d;

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign accept       = start && !busy;
    assign room         = row_count_reg < CNT_W'(MAX_CANDIDATES);
    assign i_last       = ({{(CNT_W-IDX_W){1'b0}}, i_reg} == n_reg - CNT_W'(1));
    assign j_last       = ({{(CNT_W-IDX_W){1'b0}}, j_reg} == n_reg - CNT_W'(1));
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A zero objective count acts as one; larger counts saturate at the smaller of the lane and field counts.
    always_comb
    begin
        if (obj_count_reg == '0)
        begin
            k_act = 4'd1;
        end
        else if ({1'b0, obj_count_reg} > 4'(KMAX))
        begin
            k_act = 4'(KMAX);
        end
        else
        begin
            k_act = {1'b0, obj_count_reg};
        end
        any_weight = 1'b0;
        for (int o = 0; o < FIELD_OBJECTIVES; o++)
        begin
            if ((4'(o) < k_act) && (weight_reg[o] != '0))
            begin
                any_weight = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int o = 0; o < FIELD_OBJECTIVES; o++)
            begin
                weight_reg[o] <= WEIGHT_RESET;
            end
            obj_count_reg <= OBJ_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WEIGHT_0:  weight_reg[0] <= cfg_data;
                REG_WEIGHT_1:  weight_reg[1] <= cfg_data;
                REG_WEIGHT_2:  weight_reg[2] <= cfg_data;
                REG_WEIGHT_3:  weight_reg[3] <= cfg_data;
                REG_OBJ_COUNT: obj_count_reg <= cfg_data[OBJ_COUNT_W-1:0];
                default:       ;
            endcase
        end
    end

    assign score_ext = SX_W'(best_score);
    assign index_ext = IX_W'(best_index);

    always_comb
    begin
        state_next        = state_reg;
        row_count_next    = row_count_reg;
        overflow_next     = overflow_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        n_next            = n_reg;
        dcnt_next         = dcnt_reg;
        cmp_valid_next    = 1'b0;
        cmp_self_next     = (i_reg == j_reg);
        cmp_last_next     = j_last;
        cmp_i_next        = i_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        row_count_next = row_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (row.last_candidate)
                    begin
                        row_count_next = '0;
                        overflow_next  = 1'b0;
                        if (overflow_reg || !room)
                        begin
                            result_valid_next = 1'b1;
                            result_next       = '{best_index: '0, best_score: '0,
                                                  error_code: ERR_OVERFLOW};
                        end
                        else if (!any_weight)
                        begin
                            result_valid_next = 1'b1;
                            result_next       = '{best_index: '0, best_score: '0,
                                                  error_code: ERR_NO_WEIGHT};
                        end
                        else
                        begin
                            n_next     = row_count_reg + CNT_W'(1);
                            i_next     = '0;
                            j_next     = '0;
                            state_next = S_RANK;
                        end
                    end
                end
            end
            S_RANK:
            begin
                cmp_valid_next = 1'b1;
                if (j_last)
                begin
                    j_next = '0;
                    if (i_last)
                    begin
                        i_next     = '0;
                        state_next = S_RDRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_RDRAIN: state_next = S_NREAD;
            S_NREAD:  state_next = S_NLOAD;
            S_NLOAD:
            begin
                dcnt_next  = '0;
                state_next = S_NDIV;
            end
            S_NDIV:
            begin
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(DIV_W - 1))
                begin
                    state_next = S_NMUL;
                end
            end
            S_NMUL:   state_next = S_NSUM;
            S_NSUM:   state_next = S_NCMP;
            S_NCMP:
            begin
                if (i_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_NREAD;
                end
            end
            S_DONE:
            begin
                result_valid_next = 1'b1;
                result_next       = '{best_index: index_ext[INDEX_OUT_W-1:0],
                                      best_score: score_ext[SCORE_OUT_W-1:0],
                                      error_code: ERR_OK};
                state_next        = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            row_count_reg    <= '0;
            overflow_reg     <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            n_reg            <= '0;
            dcnt_reg         <= '0;
            cmp_valid_reg    <= 1'b0;
            cmp_self_reg     <= 1'b0;
            cmp_last_reg     <= 1'b0;
            cmp_i_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_count_reg    <= row_count_next;
            overflow_reg     <= overflow_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            n_reg            <= n_next;
            dcnt_reg         <= dcnt_next;
            cmp_valid_reg    <= cmp_valid_next;
            cmp_self_reg     <= cmp_self_next;
            cmp_last_reg     <= cmp_last_next;
            cmp_i_reg        <= cmp_i_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign lane_ctrl = '{
        load_wr:   accept && room,
        rank_clr:  (state_reg == S_IDLE),
        cmp_valid: cmp_valid_reg,
        cmp_self:  cmp_self_reg,
        cmp_last:  cmp_last_reg,
        div_load:  (state_reg == S_NLOAD),
        div_step:  (state_reg == S_NDIV),
        mul_en:    (state_reg == S_NMUL)
    };

    assign merge_ctrl = '{
        sum_en: (state_reg == S_NSUM),
        cmp_en: (state_reg == S_NCMP),
        first:  (i_reg == '0)
    };

    for (genvar o = 0; o < NUM_OBJECTIVES; o++)
    begin : g_lane
        logic [RAW_EXT_W-1:0]     raw_ext;
        logic [FITNESS_WIDTH-1:0] key;
        logic [WEIGHT_W-1:0]      lane_weight;

        if (o < FIELD_OBJECTIVES)
        begin : g_field
            assign raw_ext     = RAW_EXT_W'(field[o]);
            assign lane_weight = weight_reg[o];
        end
        else
        begin : g_pad
            assign raw_ext     = '0;
            assign lane_weight = '0;
        end

        // Flipping the sign bit makes unsigned order follow signed order.
        assign key = raw_ext[FITNESS_WIDTH-1:0] ^ {1'b1, {(FITNESS_WIDTH-1){1'b0}}};

        wrcs_lane #(
            .MAX_CANDIDATES (MAX_CANDIDATES),
            .FITNESS_WIDTH  (FITNESS_WIDTH)
        ) u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (lane_ctrl),
            .wr_addr      (row_count_reg[IDX_W-1:0]),
            .wr_key       (key),
            .addr_i       (i_reg),
            .addr_j       (j_reg),
            .rank_wr_addr (cmp_i_reg),
            .weight       (lane_weight),
            .active       (5'(o) < {1'b0, k_act}),
            .prod         (prod[o])
        );
    end

    wrcs_merge #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .NUM_OBJECTIVES (NUM_OBJECTIVES)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (merge_ctrl),
        .idx        (i_reg),
        .prod       (prod),
        .best_score (best_score),
        .best_index (best_index)
    );

`ifndef NO_ASSERTIONS
    a_last_row_answers: assert property (@(posedge clk) disable iff (!rst_n)
        accept && row.last_candidate |=> result_valid || busy)
        else $error("last row neither answered nor started ranking");

    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> result_valid && result.error_code == ERR_OK)
        else $error("finished ranking without an ok result");

    a_cmp_from_rank: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> $past(state_reg == S_RANK))
        else $error("rank compare outside the ranking pass");

    a_store_emptied: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> row_count_reg == '0 && !overflow_reg)
        else $error("store not emptied after a result");
`endif

endmodule

`default_nettype wire
